>>> src/eod_pkg.sv
// eod_pkg: shared types and constants of the energy onset detector
// depends on nothing; every other file of the block uses it
package eod_pkg;

    // fixed field widths
    localparam int WS_W        = 16;
    localparam int THR_W       = 10;
    localparam int CNT_W       = 16;
    localparam int WIN_START_W = 32;
    localparam int LEVEL_W     = 13;
    localparam int LVL_W       = 12;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    // log2 unit: Q30 mantissa, 16 fraction bits
    localparam int MANT_W = 31;
    localparam int FRAC_W = 16;
    localparam int ITER_W = 4;

    // 160*log10(2) in Q16, converts octaves to 1/16 dB
    localparam logic [21:0] DB_PER_OCTAVE_Q16 = 22'd3156528;
    localparam logic [LVL_W-1:0] SILENT_LEVEL = 12'd3200;

    // register map
    localparam logic REG_WINDOW_SAMPLES = 1'b0;
    localparam logic REG_RISE_THRESHOLD = 1'b1;
    localparam logic [WS_W-1:0]  WINDOW_SAMPLES_RST = 16'd960;
    localparam logic [THR_W-1:0] RISE_THRESHOLD_RST = 10'd96;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_LOAD_S,
        ST_NORM,
        ST_ITER_MUL,
        ST_ITER_ADJ,
        ST_LOG_DONE,
        ST_LOAD_C,
        ST_SCALE_MUL,
        ST_SCALE,
        ST_HIST_INIT,
        ST_HIST_STEP,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        MUL_SAMPLE,
        MUL_MANT,
        MUL_SCALE
    } t_mul_sel;

    typedef struct packed {
        logic     take;
        t_mul_sel mul_sel;
        logic     acc;
        logic     load_s;
        logic     load_c;
        logic     norm_shift;
        logic     iter_adj;
        logic     log_done;
        logic     level_silent;
        logic     level_scale;
        logic     hist_clr;
        logic     hist_step;
        logic     emit;
    } t_dp_cmd;

    typedef struct packed {
        logic close;
        logic sum_zero;
        logic norm_done;
        logic iter_last;
        logic log_is_s;
        logic hist_empty;
        logic hist_last;
        logic out_free;
    } t_dp_status;

endpackage

>>> src/eod_if.sv
// eod_if: valid/ready channels of the energy onset detector
// sample word in, window word out; depends on eod_pkg
interface eod_in_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          end_of_range;

    modport source (output valid, sample, end_of_range, input ready);
    modport sink   (input valid, sample, end_of_range, output ready);
endinterface

interface eod_out_if ();
    logic                                    valid;
    logic                                    ready;
    logic [eod_pkg::WIN_START_W-1:0]         window_start;
    logic signed [eod_pkg::LEVEL_W-1:0]      level_db;
    logic                                    onset;
    logic                                    range_done;

    modport source (output valid, window_start, level_db, onset, range_done, input ready);
    modport sink   (input valid, window_start, level_db, onset, range_done, output ready);
endinterface

>>> src/eod_cfg.sv
// eod_cfg: APB register file with window length and rise threshold
// depends on eod_pkg
module eod_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [eod_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [eod_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [eod_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [eod_pkg::WS_W-1:0]         o_window_samples,
    output logic [eod_pkg::THR_W-1:0]        o_rise_threshold
);
    import eod_pkg::*;

    logic [WS_W-1:0]  r_window_samples;
    logic [THR_W-1:0] r_rise_threshold;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_samples <= WINDOW_SAMPLES_RST;
            r_rise_threshold <= RISE_THRESHOLD_RST;
        end else if (wr_en) begin
            case (paddr[2])
                REG_WINDOW_SAMPLES: r_window_samples <= pwdata[WS_W-1:0];
                REG_RISE_THRESHOLD: r_rise_threshold <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WINDOW_SAMPLES: prdata = CFG_DATA_W'(r_window_samples);
            REG_RISE_THRESHOLD: prdata = CFG_DATA_W'(r_rise_threshold);
            default:            prdata = '0;
        endcase
    end

    assign o_window_samples = r_window_samples;
    assign o_rise_threshold = r_rise_threshold;

endmodule

>>> src/eod_ctrl.sv
// eod_ctrl: sequencer of the energy onset detector
// steps the datapath through accumulate, log2, scale and history; depends on eod_pkg
module eod_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  eod_pkg::t_dp_status i_status,
    output eod_pkg::t_dp_cmd    o_cmd
);
    import eod_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (i_in_valid) n_state = ST_SQUARE;
            ST_SQUARE:    n_state = ST_ACCUM;
            ST_ACCUM:     n_state = i_status.close ? ST_LOAD_S : ST_IDLE;
            ST_LOAD_S:    n_state = i_status.sum_zero ? ST_HIST_INIT : ST_NORM;
            ST_NORM:      if (i_status.norm_done) n_state = ST_ITER_MUL;
            ST_ITER_MUL:  n_state = ST_ITER_ADJ;
            ST_ITER_ADJ:  n_state = i_status.iter_last ? ST_LOG_DONE : ST_ITER_MUL;
            ST_LOG_DONE:  n_state = i_status.log_is_s ? ST_LOAD_C : ST_SCALE_MUL;
            ST_LOAD_C:    n_state = ST_NORM;
            ST_SCALE_MUL: n_state = ST_SCALE;
            ST_SCALE:     n_state = ST_HIST_INIT;
            ST_HIST_INIT: n_state = i_status.hist_empty ? ST_EMIT : ST_HIST_STEP;
            ST_HIST_STEP: if (i_status.hist_last) n_state = ST_EMIT;
            ST_EMIT:      if (i_status.out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_MANT;
        o_in_ready    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            ST_SQUARE:    o_cmd.mul_sel = MUL_SAMPLE;
            ST_ACCUM:     o_cmd.acc = 1'b1;
            ST_LOAD_S: begin
                o_cmd.load_s       = 1'b1;
                o_cmd.level_silent = i_status.sum_zero;
            end
            ST_NORM:      o_cmd.norm_shift = 1'b1;
            ST_ITER_MUL:  o_cmd.mul_sel = MUL_MANT;
            ST_ITER_ADJ:  o_cmd.iter_adj = 1'b1;
            ST_LOG_DONE:  o_cmd.log_done = 1'b1;
            ST_LOAD_C:    o_cmd.load_c = 1'b1;
            ST_SCALE_MUL: o_cmd.mul_sel = MUL_SCALE;
            ST_SCALE:     o_cmd.level_scale = 1'b1;
            ST_HIST_INIT: o_cmd.hist_clr = 1'b1;
            ST_HIST_STEP: o_cmd.hist_step = 1'b1;
            ST_EMIT:      o_cmd.emit = i_status.out_free;
            default: ;
        endcase
    end

endmodule

>>> src/eod_dp.sv
// eod_dp: datapath of the energy onset detector
// square/accumulate, shared multiplier, iterative log2, level history; depends on eod_pkg
module eod_dp #(
    parameter int HISTORY_LEN   = 5,
    parameter int SAMPLE_BITS   = 16,
    parameter int POSITION_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  eod_pkg::t_dp_cmd                   i_cmd,
    output eod_pkg::t_dp_status                o_status,
    input  logic [eod_pkg::WS_W-1:0]           i_window_samples,
    input  logic [eod_pkg::THR_W-1:0]          i_rise_threshold,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample,
    input  logic                               i_end_of_range,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [eod_pkg::WIN_START_W-1:0]    o_window_start,
    output logic signed [eod_pkg::LEVEL_W-1:0] o_level_db,
    output logic                               o_onset,
    output logic                               o_range_done
);
    import eod_pkg::*;

    localparam int SUM_W  = 2 * SAMPLE_BITS + 14;
    localparam int NORM_W = (SUM_W > MANT_W) ? SUM_W : MANT_W;
    localparam int TOP_W  = $clog2(NORM_W);
    localparam int LOG_W  = TOP_W + FRAC_W;
    localparam int DIFF_W = LOG_W + 2;
    localparam int MAG_W  = LOG_W + 1;
    localparam int OFS    = 2 * (SAMPLE_BITS - 1) * (2 ** FRAC_W);
    localparam int PROD_W = 2 * MANT_W;
    localparam int HC_W   = $clog2(HISTORY_LEN + 1);
    localparam int HI_W   = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
    localparam int TERM_W = 15;
    localparam int ACC_W  = TERM_W + HC_W;

    // sample side
    logic [SAMPLE_BITS-1:0] raw_u;
    logic [SAMPLE_BITS-1:0] smag_in;
    logic [SAMPLE_BITS-1:0] r_smag;
    logic                   r_last;
    logic [SUM_W-1:0]       r_sum;
    logic [CNT_W-1:0]       r_cnt;
    logic [WS_W-1:0]        limit;
    logic                   close;
    logic [POSITION_BITS-1:0]    r_origin;
    logic [POSITION_BITS+31:0]   origin_ext;

    // shared multiplier
    logic [MANT_W-1:0] mul_a;
    logic [MANT_W-1:0] mul_b;
    logic [PROD_W-1:0] r_prod;

    // log2 unit
    logic [NORM_W-1:0] r_norm;
    logic [TOP_W-1:0]  r_top;
    logic [FRAC_W-1:0] r_frac;
    logic [ITER_W-1:0] r_iter;
    logic              r_src;
    logic [LOG_W-1:0]  r_log_s;
    logic [LOG_W-1:0]  log_cur;
    logic              norm_done;
    logic              sq_bit;
    logic [MANT_W-1:0] mant_next;
    logic signed [DIFF_W-1:0] diff;
    logic [MAG_W-1:0]  mag_next;
    logic [MAG_W-1:0]  r_mag;

    // level scaling
    logic [PROD_W-1:0]    rnd;
    logic [PROD_W-33:0]   lv_raw;
    logic [LVL_W-1:0]     level_next;
    logic [LVL_W-1:0]     r_level;

    // history, levels kept as magnitudes (newest at entry 0)
    logic [LVL_W-1:0]          r_hist [HISTORY_LEN];
    logic [HC_W-1:0]           r_hcnt;
    logic [HI_W-1:0]           r_hidx;
    logic signed [ACC_W-1:0]   r_hacc;
    logic                      r_rise;
    logic [LVL_W-1:0]          hist_rd;
    logic signed [TERM_W-1:0]  term;
    logic                      rise_now;
    logic                      hist_last;
    logic                      onset_now;

    // output word
    logic                       r_out_valid;
    logic [WIN_START_W-1:0]     r_o_start;
    logic signed [LEVEL_W-1:0]  r_o_level;
    logic                       r_o_onset;
    logic                       r_o_done;
    logic                       out_free;

    assign raw_u   = i_sample;
    assign smag_in = raw_u[SAMPLE_BITS-1] ? (~raw_u + SAMPLE_BITS'(1)) : raw_u;

    assign limit = (i_window_samples == '0) ? WS_W'(1) : i_window_samples;
    assign close = (({1'b0, r_cnt} + 17'd1) >= {1'b0, limit}) || r_last;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_SAMPLE: begin
                mul_a = MANT_W'(r_smag);
                mul_b = MANT_W'(r_smag);
            end
            MUL_MANT: begin
                mul_a = r_norm[NORM_W-1 -: MANT_W];
                mul_b = r_norm[NORM_W-1 -: MANT_W];
            end
            MUL_SCALE: begin
                mul_a = MANT_W'(r_mag);
                mul_b = MANT_W'(DB_PER_OCTAVE_Q16);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign norm_done = r_norm[NORM_W-1] || (r_top == '0);

    // squared mantissa >= 2.0 yields a one bit and is halved
    assign sq_bit    = r_prod[PROD_W-1];
    assign mant_next = sq_bit ? r_prod[PROD_W-1 -: MANT_W] : r_prod[PROD_W-2 -: MANT_W];
    assign log_cur   = {r_top, r_frac};

    // octaves below full scale, clamped at zero
    assign diff = $signed({2'b00, log_cur}) - $signed({2'b00, r_log_s})
                + $signed(DIFF_W'(OFS));
    assign mag_next = diff[DIFF_W-1] ? '0 : diff[DIFF_W-2:0];

    assign rnd        = r_prod + (PROD_W'(1) << 31);
    assign lv_raw     = rnd[PROD_W-1:32];
    assign level_next = (lv_raw > (PROD_W-32)'(SILENT_LEVEL)) ? SILENT_LEVEL
                                                               : lv_raw[LVL_W-1:0];

    // sum over history of 2*H - 2*L - thr must come out positive
    assign hist_rd  = r_hist[r_hidx];
    assign term     = $signed({2'b00, hist_rd, 1'b0}) - $signed({2'b00, r_level, 1'b0})
                    - $signed({5'b00000, i_rise_threshold});
    assign rise_now = ($signed({2'b00, hist_rd}) - $signed({2'b00, r_level}))
                    >= $signed({4'b0000, i_rise_threshold});
    assign hist_last = ((HC_W'(r_hidx) + HC_W'(1)) == r_hcnt);
    assign onset_now = (r_hcnt != '0) && r_rise && (r_hacc > 0);

    assign out_free   = !r_out_valid || i_out_ready;
    assign origin_ext = {32'd0, r_origin};

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;

        if (!i_rst_n) begin
            r_sum       <= '0;
            r_cnt       <= '0;
            r_origin    <= '0;
            r_hcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                r_smag <= smag_in;
                r_last <= i_end_of_range;
            end

            if (i_cmd.acc) begin
                r_sum <= r_sum + SUM_W'(r_prod[2*SAMPLE_BITS-1:0]);
                r_cnt <= r_cnt + CNT_W'(1);
            end

            if (i_cmd.load_s || i_cmd.load_c) begin
                r_norm <= i_cmd.load_s ? NORM_W'(r_sum) : NORM_W'(r_cnt);
                r_top  <= TOP_W'(NORM_W - 1);
                r_frac <= '0;
                r_iter <= '0;
                r_src  <= i_cmd.load_s;
            end else if (i_cmd.norm_shift && !norm_done) begin
                r_norm <= r_norm << 1;
                r_top  <= r_top - TOP_W'(1);
            end else if (i_cmd.iter_adj) begin
                r_norm[NORM_W-1 -: MANT_W] <= mant_next;
                r_frac <= {r_frac[FRAC_W-2:0], sq_bit};
                r_iter <= r_iter + ITER_W'(1);
            end

            if (i_cmd.log_done) begin
                if (r_src) begin
                    r_log_s <= log_cur;
                end else begin
                    r_mag <= mag_next;
                end
            end

            if (i_cmd.level_silent) begin
                r_level <= SILENT_LEVEL;
            end else if (i_cmd.level_scale) begin
                r_level <= level_next;
            end

            if (i_cmd.hist_clr) begin
                r_hidx <= '0;
                r_hacc <= '0;
                r_rise <= 1'b0;
            end else if (i_cmd.hist_step) begin
                r_hacc <= r_hacc + ACC_W'(term);
                if (r_hidx == '0) begin
                    r_rise <= rise_now;
                end
                r_hidx <= r_hidx + HI_W'(1);
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.emit) begin
                r_o_start   <= origin_ext[WIN_START_W-1:0];
                r_o_level   <= LEVEL_W'(0) - $signed({1'b0, r_level});
                r_o_onset   <= onset_now;
                r_o_done    <= r_last;

                for (int i = HISTORY_LEN - 1; i > 0; i--) begin
                    r_hist[i] <= r_hist[i-1];
                end
                r_hist[0] <= r_level;

                r_sum <= '0;
                r_cnt <= '0;
                if (r_last) begin
                    r_hcnt   <= '0;
                    r_origin <= '0;
                end else begin
                    r_origin <= r_origin + POSITION_BITS'(r_cnt);
                    if (r_hcnt != HC_W'(HISTORY_LEN)) begin
                        r_hcnt <= r_hcnt + HC_W'(1);
                    end
                end
            end
        end
    end

    assign o_status.close      = close;
    assign o_status.sum_zero   = (r_sum == '0);
    assign o_status.norm_done  = norm_done;
    assign o_status.iter_last  = (r_iter == ITER_W'(FRAC_W - 1));
    assign o_status.log_is_s   = r_src;
    assign o_status.hist_empty = (r_hcnt == '0);
    assign o_status.hist_last  = hist_last;
    assign o_status.out_free   = out_free;

    assign o_out_valid    = r_out_valid;
    assign o_window_start = r_o_start;
    assign o_level_db     = r_o_level;
    assign o_onset        = r_o_onset;
    assign o_range_done   = r_o_done;

    a_emit_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("window word loaded while output register still full");

    a_hist_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hcnt <= HC_W'(HISTORY_LEN))
        else $error("history count beyond history length");

    a_level_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.level_scale |=> r_level <= SILENT_LEVEL)
        else $error("scaled level magnitude above silence floor");

    a_window_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_cnt == '0) && (r_sum == '0))
        else $error("window accumulator not cleared after emit");

endmodule

>>> src/energy_onset_detector.sv
// energy_onset_detector: top level, windowed RMS level and onset flag per window
// depends on eod_pkg, eod_if, eod_cfg, eod_ctrl, eod_dp
//
// usage:
//   i_smp carries one signed sample word per handshake, with end_of_range on the
//   last sample of a range. o_win carries one word per closed window: its start
//   offset in the range, RMS level in 1/16 dB (-3200 for silence), onset flag and
//   range_done. APB registers: window_samples at 0x0, rise_threshold at 0x4.
// sequence:
//   a sample that does not close a window is accepted, squared on the shared
//   multiplier and accumulated. a closing sample also runs two log2 passes
//   through one normalizer (one bit a cycle) and 16 square-and-adjust steps,
//   then one scale multiply and one step per stored history level before the
//   result word; a silent window skips the log2 passes and the scale multiply.
//   a new sample is taken only once the previous one is through.
// reset: registers return to 960 samples and a threshold of 96, window and history
//   are empty. when the receiver stalls, a finished window word waits in the output
//   register while further samples are taken; the next closing window holds until
//   that register is free.
module energy_onset_detector #(
    parameter int HISTORY_LEN   = 5,
    parameter int SAMPLE_BITS   = 16,
    parameter int POSITION_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    eod_in_if.sink                           i_smp,
    eod_out_if.source                        o_win,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [eod_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [eod_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [eod_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import eod_pkg::*;

    logic [WS_W-1:0]  window_samples;
    logic [THR_W-1:0] rise_threshold;
    logic             in_ready;
    t_dp_cmd          cmd;
    t_dp_status       status;

    eod_cfg u_cfg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_window_samples (window_samples),
        .o_rise_threshold (rise_threshold)
    );

    eod_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    eod_dp #(
        .HISTORY_LEN   (HISTORY_LEN),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_window_samples (window_samples),
        .i_rise_threshold (rise_threshold),
        .i_sample         (i_smp.sample),
        .i_end_of_range   (i_smp.end_of_range),
        .i_out_ready      (o_win.ready),
        .o_out_valid      (o_win.valid),
        .o_window_start   (o_win.window_start),
        .o_level_db       (o_win.level_db),
        .o_onset          (o_win.onset),
        .o_range_done     (o_win.range_done)
    );

    assign i_smp.ready = in_ready;

endmodule

>>> tb/sv/eod_window_checker.sv
// eod_window_checker: watches the sample, window and register ports of the energy
// onset detector, predicts every window word and compares it with the one that comes
// depends on eod_pkg and the channel interfaces in eod_if
module eod_window_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    eod_in_if                              i_smp,
    eod_out_if                             i_win,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [eod_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [eod_pkg::CFG_DATA_W-1:0] pwdata,
    input  logic [eod_pkg::CFG_DATA_W-1:0] prdata,
    input  logic                           pready,
    output int                             o_pending,
    output int                             o_errors,
    output int                             o_windows,
    output int                             o_onsets
);
    timeunit 1ns;
    timeprecision 1ps;
    import eod_pkg::*;

    localparam int SAMPLE_BITS = 16;
    localparam int HISTORY_LEN = 5;
    localparam int FULL_SCALE_OCTAVES = 2 * (SAMPLE_BITS - 1);

    typedef struct packed {
        logic [WIN_START_W-1:0]    start;
        logic signed [LEVEL_W-1:0] level;
        logic                      onset;
        logic                      range_done;
    } t_window_word;

    logic [WS_W-1:0]        win_len  = WINDOW_SAMPLES_RST;
    logic [THR_W-1:0]       rise_thr = RISE_THRESHOLD_RST;
    longint unsigned        energy   = 0;
    longint unsigned        fill     = 0;
    logic [WIN_START_W-1:0] origin   = '0;
    longint                 level_hist [HISTORY_LEN];
    int                     hist_n   = 0;
    t_window_word           expected_windows [$];
    int                     err_cnt   = 0;
    int                     win_cnt   = 0;
    int                     onset_cnt = 0;

    // log2 in Q16: top bit index plus 16 fraction bits by repeated squaring
    function automatic longint unsigned octaves_q16(input longint unsigned x);
        int              b;
        int              msb;
        longint unsigned mant;
        longint unsigned frac;
        msb  = 0;
        frac = 0;
        for (b = 0; b < 64; b++)
            if (x[b]) msb = b;
        mant = (msb >= 30) ? (x >> (msb - 30)) : (x << (30 - msb));
        repeat (16) begin
            mant = (mant * mant) >> 30;
            frac = frac << 1;
            if (mant >= (64'd1 << 31)) begin
                frac = frac | 64'd1;
                mant = mant >> 1;
            end
        end
        return (longint'(msb) << 16) + frac;
    endfunction

    function automatic longint window_level_db(input longint unsigned nrg,
                                               input longint unsigned n);
        longint          d;
        longint unsigned mag;
        longint unsigned lv;
        if (nrg == 0 || n == 0) return -longint'(SILENT_LEVEL);
        d = longint'(octaves_q16(nrg)) - longint'(octaves_q16(n))
            - longint'(FULL_SCALE_OCTAVES) * 65536;
        mag = (d >= 0) ? 64'd0 : 64'(-d);
        lv  = (mag * 64'(DB_PER_OCTAVE_Q16) + (64'd1 << 31)) >> 32;
        if (lv > 64'(SILENT_LEVEL)) lv = 64'(SILENT_LEVEL);
        return -longint'(lv);
    endfunction

    function automatic void accumulate_sample(input logic signed [SAMPLE_BITS-1:0] s,
                                              input logic last);
        longint unsigned mag;
        longint unsigned limit;
        longint          level;
        longint          hsum;
        longint          thr;
        t_window_word    w;
        int              i;
        mag    = 64'((s < 0) ? -longint'(s) : longint'(s));
        energy = energy + mag * mag;
        fill   = fill + 1;
        limit  = (win_len == 0) ? 64'd1 : 64'(win_len);
        if (fill < limit && !last) return;

        level   = window_level_db(energy, fill);
        thr     = longint'(rise_thr);
        w.onset = 1'b0;
        // first window of a range has no history and is never an onset
        if (hist_n > 0) begin
            hsum = 0;
            for (i = 0; i < hist_n; i++)
                hsum += level_hist[i];
            if (level - level_hist[hist_n-1] >= thr
                    && 2 * level * hist_n > 2 * hsum + thr * hist_n)
                w.onset = 1'b1;
        end
        w.start      = origin;
        w.level      = LEVEL_W'(level);
        w.range_done = last;
        expected_windows.insert(expected_windows.size(), w);

        if (hist_n == HISTORY_LEN) begin
            for (i = 1; i < HISTORY_LEN; i++)
                level_hist[i-1] = level_hist[i];
            level_hist[HISTORY_LEN-1] = level;
        end else begin
            level_hist[hist_n] = level;
            hist_n++;
        end
        origin = origin + WIN_START_W'(fill);
        energy = 0;
        fill   = 0;
        if (last) begin
            hist_n = 0;
            origin = '0;
        end
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            err_cnt++;
            $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_window_word want;
        if (!i_rst_n) begin
            win_len  = WINDOW_SAMPLES_RST;
            rise_thr = RISE_THRESHOLD_RST;
            energy   = 0;
            fill     = 0;
            origin   = '0;
            hist_n   = 0;
            expected_windows.delete();
        end else begin
            // outputs first: a word never belongs to a sample taken at the same edge
            if (i_win.valid && i_win.ready) begin
                win_cnt++;
                if (i_win.onset) onset_cnt++;
                if (expected_windows.size() == 0) begin
                    err_cnt++;
                    $display("%0t ns: window word with none expected, start %0d level %0d",
                             $time, i_win.window_start, i_win.level_db);
                end else begin
                    want = expected_windows.pop_front();
                    check_field("window_start", longint'(want.start),
                                longint'(i_win.window_start));
                    check_field("level_db", longint'(want.level), longint'(i_win.level_db));
                    check_field("onset", longint'(want.onset), longint'(i_win.onset));
                    check_field("range_done", longint'(want.range_done),
                                longint'(i_win.range_done));
                end
            end
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[2] == REG_WINDOW_SAMPLES)
                        win_len = pwdata[WS_W-1:0];
                    else
                        rise_thr = pwdata[THR_W-1:0];
                end else begin
                    check_field("register read",
                                (paddr[2] == REG_WINDOW_SAMPLES) ? longint'(win_len)
                                                                  : longint'(rise_thr),
                                longint'(prdata));
                end
            end
            if (i_smp.valid && i_smp.ready)
                accumulate_sample(i_smp.sample, i_smp.end_of_range);
        end
        o_pending <= expected_windows.size();
        o_errors  <= err_cnt;
        o_windows <= win_cnt;
        o_onsets  <= onset_cnt;
    end

endmodule

>>> tb/sv/tb.sv
// tb: drives samples and register writes into energy_onset_detector with bursty
// input and a stalling receiver; eod_window_checker predicts and compares the words
// depends on eod_pkg, eod_if, energy_onset_detector and eod_window_checker
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import eod_pkg::*;

    localparam int          N_PHASES     = 13;
    localparam int          PHASE_ITEMS  = 100;
    localparam int          QUIET_CYCLES = 250;
    localparam int          HOLD_CYCLES  = 1500;
    localparam int          HOLD_PHASE   = 7;
    localparam int unsigned CYCLE_LIMIT  = 1000000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int          pending;
    int          errors;
    int          windows;
    int          onsets;
    logic        hold_req;
    logic        hold_done  = 1'b0;
    logic        tx_idle_en = 1'b1;
    int          burst_left = 0;
    int          n_sent     = 0;
    int          n_writes   = 0;
    int unsigned cycle_cnt  = 0;

    eod_in_if  smp_ch ();
    eod_out_if win_ch ();

    energy_onset_detector i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_ch),
        .o_win   (win_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    eod_window_checker i_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_smp     (smp_ch),
        .i_win     (win_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_pending (pending),
        .o_errors  (errors),
        .o_windows (windows),
        .o_onsets  (onsets)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected", cycle_cnt, pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver: random stall runs, quiet stretches, one long hold-off on request
    initial begin
        int unsigned stall_left;
        int unsigned rx_cycles;
        stall_left = 0;
        rx_cycles  = 0;
        win_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rx_cycles++;
            if (hold_req && !hold_done) begin
                win_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (stall_left > 0) begin
                win_ch.ready <= 1'b0;
                stall_left--;
            end else if ((rx_cycles / 600) % 3 != 0 && $urandom_range(0, 5) == 0) begin
                win_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 14);
            end else begin
                win_ch.ready <= 1'b1;
            end
        end
    end

    function automatic int unsigned phase_window(input int ph);
        case (ph)
            0:       return 1;
            1:       return 2;
            2:       return 0;
            3:       return 4;
            4:       return 3;
            5:       return 65535;
            6:       return 7;
            7:       return 1;
            8:       return 5;
            9:       return 16;
            10:      return 960;
            11:      return 2;
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    // 0, 1 and 1023 lie outside the documented range and are used as given
    function automatic int unsigned phase_threshold(input int ph);
        case (ph)
            0:       return 2;
            1:       return 960;
            2:       return 0;
            3:       return 1023;
            4:       return 96;
            5:       return 48;
            6:       return 2;
            7:       return 30;
            8:       return 500;
            9:       return 1;
            10:      return 64;
            11:      return 960;
            default: return $urandom_range(2, 960);
        endcase
    endfunction

    // per-window loudness in bits: mostly drift, some jumps up (onsets) and drops
    function automatic int next_amp(input int amp);
        int r;
        int a;
        r = $urandom_range(0, 9);
        if (r < 5)
            a = amp + $urandom_range(0, 2) - 1;
        else if (r < 8)
            a = amp + $urandom_range(3, 8);
        else
            a = $urandom_range(0, 4);
        if (a < 0) a = 0;
        if (a > 16) a = 16;
        return a;
    endfunction

    function automatic int shaped_sample(input int amp);
        int mag;
        if (amp >= 16) return int'($urandom);
        if (amp == 0) return 0;
        mag = $urandom_range(0, (1 << amp) - 1);
        return ($urandom_range(0, 1) != 0) ? -mag : mag;
    endfunction

    task automatic send_word(input int value, input logic last);
        smp_ch.valid        <= 1'b1;
        smp_ch.sample       <= 16'(value);
        smp_ch.end_of_range <= last;
        do @(posedge i_clk); while (!smp_ch.ready);
        n_sent++;
        if (tx_idle_en) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(1, 24);
                smp_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
        end
    endtask

    // a sample that closes no window may still be in the pipe, so wait out the latency
    task automatic close_phase();
        smp_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic sel, input int unsigned value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        // read back at once, the checker compares prdata
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        n_writes++;
    endtask

    initial begin
        int          ph;
        int          amp;
        int          pos;
        int unsigned win;
        int unsigned eff;
        int unsigned eor_span;
        logic        last;

        i_rst_n             <= 1'b0;
        smp_ch.valid        <= 1'b0;
        smp_ch.sample       <= '0;
        smp_ch.end_of_range <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        hold_req            <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero length acts as one: every sample is a window, silence and full scale
        cfg_write(REG_WINDOW_SAMPLES, 0);
        cfg_write(REG_RISE_THRESHOLD, 2);
        send_word(0, 1'b0);
        send_word(-32768, 1'b0);
        send_word(32767, 1'b0);
        send_word(0, 1'b0);
        send_word(1, 1'b0);
        send_word(-1, 1'b0);
        send_word(-32768, 1'b1);
        close_phase();

        // full window, short window flushed by end of range, window full on the last sample
        cfg_write(REG_WINDOW_SAMPLES, 3);
        cfg_write(REG_RISE_THRESHOLD, 960);
        send_word(100, 1'b0);
        send_word(200, 1'b0);
        send_word(300, 1'b0);
        send_word(5, 1'b0);
        send_word(-6, 1'b1);
        send_word(7, 1'b0);
        send_word(-8, 1'b0);
        send_word(9, 1'b1);
        close_phase();

        // length lowered while a window is open: the next sample closes it
        cfg_write(REG_WINDOW_SAMPLES, 960);
        cfg_write(REG_RISE_THRESHOLD, 96);
        send_word(1000, 1'b0);
        send_word(-2000, 1'b0);
        send_word(3000, 1'b0);
        send_word(-4000, 1'b0);
        close_phase();
        cfg_write(REG_WINDOW_SAMPLES, 2);
        send_word(5000, 1'b0);
        send_word(-32768, 1'b1);
        close_phase();

        amp = 8;
        pos = 0;
        for (ph = 0; ph < N_PHASES; ph++) begin
            win = phase_window(ph);
            cfg_write(REG_WINDOW_SAMPLES, win);
            cfg_write(REG_RISE_THRESHOLD, phase_threshold(ph));
            eff      = (win == 0) ? 1 : win;
            eor_span = (eff * 6 > 60) ? 60 : eff * 6;
            tx_idle_en = (ph % 4 != 2);
            if (ph == HOLD_PHASE) hold_req <= 1'b1;
            repeat (PHASE_ITEMS) begin
                if (pos % eff == 0) amp = next_amp(amp);
                last = ($urandom_range(0, eor_span) == 0);
                send_word(($urandom_range(0, 7) == 0) ? int'($urandom) : shaped_sample(amp),
                          last);
                pos = last ? 0 : pos + 1;
            end
            close_phase();
        end

        $display("run: %0d samples over %0d register writes, window lengths 0 to 65535",
                 n_sent, n_writes);
        $display("run: %0d window words checked, %0d of them onsets", windows, onsets);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> sim.f
src/eod_pkg.sv
src/eod_if.sv
src/eod_cfg.sv
src/eod_ctrl.sv
src/eod_dp.sv
src/energy_onset_detector.sv
tb/sv/eod_window_checker.sv
tb/sv/tb.sv
